// File: rtl/core/nprf_pkg.sv
`timescale 1ns / 1ps

package nprf_pkg;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_ZERO_SUM = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_RUN,
      ST_SUM,
      ST_DECIDE,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic take;
      logic start_div;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic use_own;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/core/nprf_if.sv
`timescale 1ns / 1ps

interface nprf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] self_pressure;
   logic               is_boundary;
   logic [23:0]        link_conductance;
   logic signed [31:0] neighbour_pressure;
   logic               last_link;

   modport source (output valid, output self_pressure, output is_boundary,
                   output link_conductance, output neighbour_pressure,
                   output last_link, input ready);
   modport sink (input valid, input self_pressure, input is_boundary,
                 input link_conductance, input neighbour_pressure,
                 input last_link, output ready);
endinterface

interface nprf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pressure;
   logic signed [47:0] node_flux;
   logic [1:0]         status;

   modport source (output valid, output new_pressure, output node_flux,
                   output status, input ready);
   modport sink (input valid, input new_pressure, input node_flux,
                 input status, output ready);
endinterface

// File: rtl/core/nprf_divider.sv
`timescale 1ns / 1ps

module nprf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);

   logic [nprf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [30:0]                    rem_ff, rem_in;
   logic [63:0]                    quo_ff, quo_in;
   logic [31:0]                    rem_sh;
   logic [32:0]                    trial;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign trial  = {1'b0, rem_sh} - {2'b00, divisor};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in  = nprf_pkg::DIV_CNT_W'(nprf_pkg::DIV_STEPS - 1);
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[30:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[30:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/nprf_datapath.sv
`timescale 1ns / 1ps

module nprf_datapath #(
   parameter int MAX_DEGREE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  nprf_pkg::cmd_type   cmd,
   output nprf_pkg::stat_type  stat,
   input  logic signed [31:0]  self_pressure,
   input  logic                is_boundary,
   input  logic [23:0]         link_conductance,
   input  logic signed [31:0]  neighbour_pressure,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  new_pressure,
   output logic signed [47:0]  node_flux,
   output logic [1:0]          status
);

   localparam int CNT_W = $clog2(MAX_DEGREE + 1);
   localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

   // product stage
   logic signed [56:0] prod_w_ff, prod_w_in;
   logic signed [57:0] prod_f_ff, prod_f_in;
   logic [23:0]        stage_g_ff;
   logic               stage_add_ff, stage_add_in;
   logic signed [32:0] diff;

   // run accumulators
   logic signed [63:0] wsum_ff, wsum_in;
   logic signed [63:0] fsum_ff, fsum_in;
   logic [30:0]        gsum_ff, gsum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic signed [31:0] own_ff;
   logic               bnd_ff;

   logic signed [64:0] wsum_wide, fsum_wide;
   logic [31:0]        gsum_wide;
   logic               skip;

   // divider and result
   logic               div_busy;
   logic [63:0]        quotient;
   logic [63:0]        wsum_mag;
   logic               neg;
   logic               sat;
   logic signed [31:0] div_pres;
   logic               use_own;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] pres_ff;
   logic signed [47:0] flux_ff;
   logic [1:0]         status_ff;
   nprf_pkg::status_type st_code;

   assign diff      = 33'(self_pressure) - 33'(neighbour_pressure);
   assign prod_w_in = 57'($signed({1'b0, link_conductance})) * 57'(neighbour_pressure);
   assign prod_f_in = 58'($signed({1'b0, link_conductance})) * 58'(diff);
   assign skip      = (count_ff == CNT_W'(MAX_DEGREE));
   assign stage_add_in = cmd.take && !skip;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_add_ff <= 1'b0;
      end else begin
         stage_add_ff <= stage_add_in;
      end
      if (cmd.take) begin
         prod_w_ff  <= prod_w_in;
         prod_f_ff  <= prod_f_in;
         stage_g_ff <= link_conductance;
         own_ff     <= self_pressure;
         bnd_ff     <= is_boundary;
      end
   end

   assign wsum_wide = 65'(wsum_ff) + 65'(prod_w_ff);
   assign fsum_wide = 65'(fsum_ff) + 65'(prod_f_ff);
   assign gsum_wide = {1'b0, gsum_ff} + {8'd0, stage_g_ff};

   always_comb begin
      wsum_in  = wsum_ff;
      fsum_in  = fsum_ff;
      gsum_in  = gsum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.load_out) begin
         wsum_in  = '0;
         fsum_in  = '0;
         gsum_in  = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (cmd.take) begin
            if (skip) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         if (stage_add_ff) begin
            // saturating adds, sign of the wide sum picks the limit
            if (wsum_wide[64] != wsum_wide[63]) begin
               wsum_in = wsum_wide[64] ? SUM_MIN : SUM_MAX;
               ovf_in  = 1'b1;
            end else begin
               wsum_in = wsum_wide[63:0];
            end
            if (fsum_wide[64] != fsum_wide[63]) begin
               fsum_in = fsum_wide[64] ? SUM_MIN : SUM_MAX;
               ovf_in  = 1'b1;
            end else begin
               fsum_in = fsum_wide[63:0];
            end
            if (gsum_wide[31]) begin
               gsum_in = '1;
               ovf_in  = 1'b1;
            end else begin
               gsum_in = gsum_wide[30:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff  <= '0;
         fsum_ff  <= '0;
         gsum_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         wsum_ff  <= wsum_in;
         fsum_ff  <= fsum_in;
         gsum_ff  <= gsum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign neg      = wsum_ff[63];
   assign wsum_mag = neg ? (64'd0 - wsum_ff) : wsum_ff;

   nprf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (wsum_mag),
      .divisor  (gsum_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // clamp quotient magnitude to the signed 32-bit range
   always_comb begin
      if (neg) begin
         sat      = (|quotient[63:32]) || (quotient[31] && (|quotient[30:0]));
         div_pres = sat ? 32'sh80000000 : $signed(32'd0 - quotient[31:0]);
      end else begin
         sat      = (|quotient[63:32]) || quotient[31];
         div_pres = sat ? 32'sh7FFFFFFF : $signed(quotient[31:0]);
      end
   end

   assign use_own = bnd_ff || (gsum_ff == '0);

   always_comb begin
      if (ovf_ff) begin
         st_code = nprf_pkg::STATUS_OVERFLOW;
      end else if (!bnd_ff && (gsum_ff == '0)) begin
         st_code = nprf_pkg::STATUS_ZERO_SUM;
      end else begin
         st_code = nprf_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_out) begin
         pres_ff   <= use_own ? own_ff : div_pres;
         flux_ff   <= fsum_ff[63:16];
         status_ff <= st_code;
      end
   end

   assign stat.use_own  = use_own;
   assign stat.div_done = !div_busy;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign new_pressure = pres_ff;
   assign node_flux    = flux_ff;
   assign status       = status_ff;

endmodule

// File: rtl/core/nprf_controller.sv
`timescale 1ns / 1ps

module nprf_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  nprf_pkg::stat_type  stat,
   output nprf_pkg::cmd_type   cmd
);

   nprf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nprf_pkg::ST_RUN: begin
            if (req_valid && req_last) begin
               state_in = nprf_pkg::ST_SUM;
            end
         end
         nprf_pkg::ST_SUM: begin
            state_in = nprf_pkg::ST_DECIDE;
         end
         nprf_pkg::ST_DECIDE: begin
            state_in = stat.use_own ? nprf_pkg::ST_LOAD : nprf_pkg::ST_DIVIDE;
         end
         nprf_pkg::ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = nprf_pkg::ST_LOAD;
            end
         end
         nprf_pkg::ST_LOAD: begin
            if (stat.out_free) begin
               state_in = nprf_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = nprf_pkg::ST_RUN;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.take      = 1'b0;
      cmd.start_div = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         nprf_pkg::ST_RUN: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         nprf_pkg::ST_DECIDE: begin
            cmd.start_div = !stat.use_own;
         end
         nprf_pkg::ST_LOAD: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nprf_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/node_pressure_relax_and_flux.sv
`timescale 1ns / 1ps

// Weighted Jacobi relaxation for one network node. Links arrive as a run of
// beats, one per cycle, with last_link on the final beat; each beat adds
// g*xn, g and g*(x-xn) into saturating sums through a registered multiply
// stage. After the last beat the block adds the last products in ST_SUM,
// then in ST_DECIDE either picks the own pressure (boundary or zero
// conductance sum) or starts a restoring divider, which yields one quotient
// bit per cycle and which ST_DIVIDE waits on; ST_LOAD then loads the result
// register. Input is held off from the last beat until the result is
// loaded; a finished result waiting on the response side does not block
// the next run's beats, but its result is not loaded until the waiting one
// is taken. Beats past MAX_DEGREE are dropped and reported as overflow.
module node_pressure_relax_and_flux #(
   parameter int MAX_DEGREE = 64
) (
   input  logic       clock,
   input  logic       reset,
   nprf_req_if.sink   req_bus,
   nprf_rsp_if.source rsp_bus
);

   nprf_pkg::cmd_type  cmd;
   nprf_pkg::stat_type stat;

   nprf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_link),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nprf_datapath #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .self_pressure      (req_bus.self_pressure),
      .is_boundary        (req_bus.is_boundary),
      .link_conductance   (req_bus.link_conductance),
      .neighbour_pressure (req_bus.neighbour_pressure),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .new_pressure       (rsp_bus.new_pressure),
      .node_flux          (rsp_bus.node_flux),
      .status             (rsp_bus.status)
   );

endmodule

// File: rtl/core/nprf_checker.sv
`timescale 1ns / 1ps

module nprf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] new_pressure,
   input logic [47:0] node_flux,
   input logic [1:0]  status
);

   // req_ready stays low in the SUM and DECIDE states after a last beat
   a_hold_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready ##1 !req_ready)
      else $error("input taken too soon after last beat");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(new_pressure) && $stable(node_flux) && $stable(status)))
      else $error("response payload changed while stalled");

endmodule

bind node_pressure_relax_and_flux nprf_checker u_nprf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_last     (req_bus.last_link),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .new_pressure (rsp_bus.new_pressure),
   .node_flux    (rsp_bus.node_flux),
   .status       (rsp_bus.status)
);
